// ===== src/piecewise_linear_interpolator_top_assert.svh =====
// Assertion macros for the piecewise linear interpolator.
// Used by pli_div and the top module in src; relies on clk_i and rst_ni in scope.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define PLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Plain condition checked at every rising clock edge outside reset.
`define PLI_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`endif

// ===== src/pli_pkg.sv =====
// Package for the piecewise linear interpolator: request and result types,
// operation codes, sizes and the sequencer state type. No dependencies.
`default_nettype none
package pli_pkg;
  localparam int MaxKnots   = 16;
  localparam int Components = 4;
  localparam int KnotW      = $clog2(MaxKnots);
  localparam int CompW      = $clog2(Components);
  localparam int ValAddrW   = KnotW + CompW;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_POS   = 2'd1,
    OP_SLOPE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic REG_EXTRAPOLATE = 1'b0;
  localparam logic REG_KNOT_COUNT  = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         knot_index;
    logic [1:0]         component;
    logic signed [31:0] knot_time;
    logic signed [31:0] knot_value;
    logic signed [31:0] query_time;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               error;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_END_RD, ST_END_WT, ST_SRCH_RD, ST_SRCH_WT, ST_SEG_RD,
    ST_SEG_WT, ST_DIV_GO, ST_DIV_WT, ST_DONE
  } state_e;

  // divider request/response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== src/pli_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on pli_pkg.
`default_nettype none
`include "piecewise_linear_interpolator_top_assert.svh"
module pli_div (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pli_pkg::div_req_t req_i,
  output pli_pkg::div_rsp_t    rsp_o
);
  import pli_pkg::*;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0]; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[63]}; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  `PLI_ASSERT(a_div_done, done_q |-> $past(busy_q), "divider done without run")
  `PLI_ASSERT(a_div_excl, !(done_q && busy_q), "divider done while busy")
  `PLI_ASSERT(a_div_start, req_i.start |=> busy_q && cnt_q == 7'd64, "divider start lost")
endmodule
`default_nettype wire

// ===== src/pli_mem.sv =====
// Knot time and knot value memories with a registered synchronous read.
// Depends on pli_pkg.
`default_nettype none
module pli_mem (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [pli_pkg::KnotW-1:0]  wr_knot_i,
  input  wire logic [pli_pkg::CompW-1:0]  wr_comp_i,
  input  wire logic [31:0]              wr_time_i,
  input  wire logic [31:0]              wr_val_i,
  input  wire logic [pli_pkg::KnotW-1:0]  rd_knot_i,
  input  wire logic [pli_pkg::CompW-1:0]  rd_comp_i,
  output logic [31:0]                   rd_time_o,
  output logic [31:0]                   rd_val_o
);
  import pli_pkg::*;
  logic [31:0] times_mem [MaxKnots];
  logic [31:0] vals_mem  [MaxKnots*Components];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      times_mem[wr_knot_i] <= wr_time_i;
      vals_mem[{wr_knot_i, wr_comp_i}] <= wr_val_i;
    end
    rd_time_o <= times_mem[rd_knot_i];
    rd_val_o  <= vals_mem[{rd_knot_i, rd_comp_i}];
  end
endmodule
`default_nettype wire

// ===== src/piecewise_linear_interpolator_top.sv =====
// Piecewise linear interpolator: sequencer, config registers, knot memories
// and the shared divider. Depends on pli_pkg, pli_mem and pli_div.
//
// Usage: requests arrive on req_i with req_valid_i / req_stall_o; each gives
// exactly one result on res_o with res_valid_o / res_stall_i. A write stores
// one knot time and one component value and answers zero. A position or
// slope query first reads the two end knots, then walks the knot time memory
// with a read and a wait state per knot to find the segment, reads both
// segment knots, and divides the exact product dy*dt (or dy*65536) by the
// segment length with a 64-step restoring divider. A write or an ignored
// request is answered from the done state, a clamped position once the end
// knots are read, an exact knot hit or a failed search from the search, and
// any other query when the divider is done. One request is in flight at a
// time: req_stall_o stays high until the result register is loaded and
// while that result is stalled, so the next request can be taken in the
// same cycle that the result appears. Reset clears control state and sets
// extrapolate to 0 and knot_count to 2; knot memories are undefined until
// written. Write configuration (cfg_we_i, cfg_idx_i, cfg_data_i) only while
// idle.
`default_nettype none
`include "piecewise_linear_interpolator_top_assert.svh"
module piecewise_linear_interpolator_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [4:0]    cfg_data_i,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire pli_pkg::req_t req_i,
  output logic               res_valid_o,
  input  wire logic          res_stall_i,
  output pli_pkg::res_t      res_o
);
  import pli_pkg::*;

  logic       extrap_q;
  logic [4:0] kcnt_q;
  state_e     state_q, state_d;
  req_t       rq_q;
  logic [3:0] last;
  logic [3:0] i_q, i_d;            // search index / segment base
  logic       endp_q, endp_d;      // end pass: 0 first end, 1 last end
  logic signed [32:0] t0_q, t0_d, tn_q, tn_d; // end times
  logic signed [32:0] v0_q, v0_d;  // first end value
  logic signed [32:0] tq_q, tq_d;  // effective time for segment search
  logic       mode_pos_q, mode_pos_d; // interior position
  logic       ext_q, ext_d;        // extrapolation from end knot
  logic       exthi_q, exthi_d;
  logic       sph_q, sph_d;        // segment read phase: 0 knot i, 1 knot i+1
  logic signed [32:0] ta_q, ta_d, va_q, va_d;
  logic signed [33:0] dy_q, dy_d, dt_q, dt_d, h_q, h_d;
  logic       neg_q, neg_d, hz_q, hz_d, zn_q, zn_d;
  logic signed [34:0] base_q, base_d;
  res_t       out_q, out_d;
  logic       ovalid_q, ovalid_d;
  logic       accept, fin;
  res_t       fin_res;
  logic [3:0] rd_knot;
  logic [31:0] rd_time, rd_val;
  logic signed [32:0] rt, rv;
  div_req_t   dreq;
  div_rsp_t   drsp;
  logic [63:0] prod;
  logic [33:0] mdy, mdt, mh;

  assign last = (kcnt_q < 5'd2) ? 4'd1 : ((kcnt_q > 5'd16) ? 4'd15 : 4'(kcnt_q - 5'd1));
  assign rt = 33'(signed'(rd_time));
  assign rv = 33'(signed'(rd_val));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extrap_q <= 1'b0; kcnt_q <= 5'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EXTRAPOLATE: extrap_q <= cfg_data_i[0];
        REG_KNOT_COUNT:  kcnt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req_stall_o = (state_q != ST_IDLE) || (ovalid_q && res_stall_i);
  assign accept = req_valid_i && !req_stall_o;

  pli_mem u_mem (
    .clk_i, .we_i(accept && req_i.operation == OP_WRITE),
    .wr_knot_i(req_i.knot_index), .wr_comp_i(req_i.component),
    .wr_time_i(req_i.knot_time), .wr_val_i(req_i.knot_value),
    .rd_knot_i(rd_knot), .rd_comp_i(rq_q.component),
    .rd_time_o(rd_time), .rd_val_o(rd_val)
  );

  pli_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = (req_i.operation == OP_POS ||
                                         req_i.operation == OP_SLOPE) ? ST_END_RD : ST_DONE;
      ST_END_RD:  state_d = ST_END_WT;
      ST_END_WT:  state_d = endp_q ? ST_SRCH_RD : ST_END_RD;
      ST_SRCH_RD: state_d = (mode_pos_q || ext_q || rq_q.operation == OP_SLOPE)
                            ? ST_SRCH_WT : ST_DONE;
      ST_SRCH_WT: state_d = (rt >= tq_q || i_q == last) ? ST_SEG_RD : ST_SRCH_RD;
      ST_SEG_RD:  state_d = ST_SEG_WT;
      ST_SEG_WT:  state_d = sph_q ? ST_DIV_GO : ST_SEG_RD;
      ST_DIV_GO:  state_d = ST_DIV_WT;
      ST_DIV_WT:  if (drsp.done) state_d = ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
    // a search that ran off the end finds no segment
    if (state_q == ST_SRCH_WT && rt < tq_q && i_q == last) state_d = ST_DONE;
    // exact hit at an interior knot during a position search
    if (state_q == ST_SRCH_WT && mode_pos_q && rt == tq_q) state_d = ST_DONE;
  end

  assign prod = 64'(mdy[32:0]) * 64'(mdt[32:0]);

  always_comb begin
    logic signed [35:0] sum;
    logic [63:0] q;
    logic [40:0] qc;
    logic signed [41:0] qs;
    sum = '0; q = '0; qc = '0; qs = '0;
    i_d = i_q; endp_d = endp_q; t0_d = t0_q; tn_d = tn_q; v0_d = v0_q;
    tq_d = tq_q; mode_pos_d = mode_pos_q; ext_d = ext_q; exthi_d = exthi_q;
    sph_d = sph_q; ta_d = ta_q; va_d = va_q; dy_d = dy_q; dt_d = dt_q; h_d = h_q;
    neg_d = neg_q; hz_d = hz_q; zn_d = zn_q; base_d = base_q;
    rd_knot = '0; dreq = '0; fin = 1'b0; fin_res = '0;
    mdy = dy_q[33] ? 34'(-dy_q) : 34'(dy_q);
    mdt = dt_q[33] ? 34'(-dt_q) : 34'(dt_q);
    mh  = h_q[33]  ? 34'(-h_q)  : 34'(h_q);
    unique case (state_q)
      ST_IDLE: begin
        endp_d = 1'b0; i_d = '0; sph_d = 1'b0;
      end
      ST_END_RD: rd_knot = endp_q ? last : 4'd0;
      ST_END_WT: begin
        if (!endp_q) begin
          t0_d = rt; v0_d = rv; endp_d = 1'b1;
        end else begin
          tn_d = rt;
          mode_pos_d = 1'b0; ext_d = 1'b0; exthi_d = 1'b0;
          tq_d = 33'(rq_q.query_time);
          base_d = '0;
          if (rq_q.operation == OP_POS) begin
            // end segment search runs at the end time clamped to the knot range
            if (tq_d <= t0_q) begin
              ext_d = extrap_q; base_d = 35'(v0_q);
              tq_d = (t0_q >= rt) ? rt : t0_q;
            end else if (tq_d >= rt) begin
              ext_d = extrap_q; exthi_d = 1'b1; base_d = 35'(rv);
              tq_d = (rt < t0_q) ? t0_q : rt;
            end else mode_pos_d = 1'b1;
          end else begin
            if (tq_d < t0_q) tq_d = t0_q;
            else if (tq_d >= rt) tq_d = rt;
          end
          i_d = 4'd1;
        end
      end
      ST_SRCH_RD: rd_knot = i_q;
      ST_SRCH_WT: begin
        if (rt >= tq_q || i_q == last) i_d = i_q - 4'd1;
        else i_d = i_q + 4'd1;
      end
      ST_SEG_RD: rd_knot = sph_q ? (i_q + 4'd1) : i_q;
      ST_SEG_WT: begin
        if (!sph_q) begin
          ta_d = rt; va_d = rv; sph_d = 1'b1;
        end else begin
          dy_d = 34'(rv) - 34'(va_q);
          h_d  = 34'(rt) - 34'(ta_q);
          if (rq_q.operation == OP_SLOPE) dt_d = 34'sd65536;
          else if (mode_pos_q) begin
            dt_d = 34'(33'(rq_q.query_time)) - 34'(ta_q); base_d = 35'(va_q);
          end else dt_d = 34'(33'(rq_q.query_time)) - 34'(exthi_q ? tn_q : t0_q);
        end
      end
      ST_DIV_GO: begin
        zn_d  = (dy_q == '0) || (dt_q == '0);
        hz_d  = (h_q == '0);
        neg_d = (dy_q[33] != dt_q[33]) != h_q[33];
        dreq.start = 1'b1; dreq.num = prod; dreq.den = mh[32:0];
      end
      ST_DIV_WT: ;
      ST_DONE: ;
      default: ;
    endcase

    // finishing
    if (state_q == ST_DONE) begin
      fin = 1'b1;
    end
    if (state_q == ST_SRCH_RD && !(mode_pos_q || ext_q || rq_q.operation == OP_SLOPE)) begin
      fin = 1'b1; sum = 36'(base_q);
    end
    if (state_q == ST_SRCH_WT && rt < tq_q && i_q == last) begin
      fin = 1'b1; sum = ext_q ? 36'(base_q) : '0;
    end
    if (state_q == ST_SRCH_WT && mode_pos_q && rt == tq_q) begin
      fin = 1'b1; sum = 36'(rv);
    end
    if (state_q == ST_DIV_WT && drsp.done) begin
      fin = 1'b1;
      q = drsp.quo;
      if (zn_q) begin
        qc = '0; fin_res.error = hz_q;
      end else if (hz_q) begin
        qc = 41'h100_0000_0000; fin_res.error = 1'b1;
      end else qc = (q > 64'h100_0000_0000) ? 41'h100_0000_0000 : q[40:0];
      if (hz_q && !zn_q) qs = ((dy_q[33] != dt_q[33])) ? -42'(qc) : 42'(qc);
      else qs = neg_q ? -42'(qc) : 42'(qc);
      // clip well past the 32-bit range so the sum cannot wrap
      sum = 36'(base_q) + 36'(qs > 42'sd8589934591 ? 42'sd8589934591 :
             (qs < -42'sd8589934592 ? -42'sd8589934592 : qs));
    end
    if (fin && state_q != ST_DONE) begin
      if (sum > 36'sd2147483647) begin
        fin_res.result_value = 32'h7FFF_FFFF; fin_res.error = 1'b1;
      end else if (sum < -36'sd2147483648) begin
        fin_res.result_value = 32'h8000_0000; fin_res.error = 1'b1;
      end else fin_res.result_value = sum[31:0];
    end
  end

  // result register: ST_DONE carries writes and ignored requests (zero)
  always_comb begin
    out_d = out_q;
    ovalid_d = ovalid_q && res_stall_i;
    if (fin) begin
      out_d = fin_res; ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ovalid_q <= 1'b0;
    end else begin
      state_q <= (fin) ? ST_IDLE : state_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) rq_q <= req_i;
    i_q <= i_d; endp_q <= endp_d; t0_q <= t0_d; tn_q <= tn_d; v0_q <= v0_d;
    tq_q <= tq_d; mode_pos_q <= mode_pos_d; ext_q <= ext_d;
    exthi_q <= exthi_d; sph_q <= sph_d; ta_q <= ta_d; va_q <= va_d; dy_q <= dy_d;
    dt_q <= dt_d; h_q <= h_d; neg_q <= neg_d; hz_q <= hz_d; zn_q <= zn_d;
    base_q <= base_d; out_q <= out_d;
  end

  assign res_valid_o = ovalid_q;
  assign res_o = out_q;

  `PLI_ASSERT(a_one_flight, accept |=> state_q != ST_IDLE, "request not taken")
  `PLI_ASSERT(a_no_overrun, fin |-> !(ovalid_q && res_stall_i), "result overwritten")
  `PLI_ASSERT(a_res_hold, ovalid_q && res_stall_i |=> ovalid_q && $stable(out_q),
              "stalled result changed")
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for piecewise_linear_interpolator_top: loads knot tables,
// sweeps the configuration and checks every result against its own interpolator.
// Depends on pli_pkg and the RTL in src.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  localparam longint QuotLimit = longint'(1) << 40;

  // Holds the knot table and configuration, computes each result and queues it.
  class interp_scoreboard;
    logic [31:0] times[MaxKnots];
    logic [31:0] values[MaxKnots][Components];
    bit          extrap_on;
    int          count_reg;
    bit          sat_flag;
    res_t        pending[$];
    int          errors;

    function new();
      extrap_on = 1'b0;
      count_reg = 2;
      errors    = 0;
      for (int i = 0; i < MaxKnots; i++) begin
        times[i] = '0;
        for (int c = 0; c < Components; c++) values[i][c] = '0;
      end
    endfunction

    function longint kt(int i);
      return longint'($signed(times[i]));
    endfunction

    function longint kv(int i, int c);
      return longint'($signed(values[i][c]));
    endfunction

    function int knots_used();
      if (count_reg < 2) return 2;
      if (count_reg > MaxKnots) return MaxKnots;
      return count_reg;
    endfunction

    // a * b / h toward zero, product wraps at 64 bits, quotient clipped
    function longint scale(longint a, longint b, longint h);
      longint unsigned ua, ub, uh, q;
      bit neg_num;
      ua = (a < 0) ? longint'(-a) : a;
      ub = (b < 0) ? longint'(-b) : b;
      uh = (h < 0) ? longint'(-h) : h;
      neg_num = (a < 0) != (b < 0);
      if (ua == 0 || ub == 0) begin
        if (uh == 0) sat_flag = 1'b1;
        return 0;
      end
      if (uh == 0) begin
        sat_flag = 1'b1;
        return neg_num ? -QuotLimit : QuotLimit;
      end
      q = (ua * ub) / uh;
      if (q > longint'(QuotLimit)) q = QuotLimit;
      return (neg_num != (h < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function int seg_for_slope(longint t, int n);
      if (t < kt(0)) t = kt(0);
      else if (t >= kt(n - 1)) t = kt(n - 1);
      for (int i = 0; i < n - 1; i++)
        if (t <= kt(i + 1)) return i;
      return -1;
    endfunction

    function longint beyond_end(int e, longint t, int c, int n);
      int s;
      s = seg_for_slope(kt(e), n);
      if (s < 0) return kv(e, c);
      return kv(e, c) + scale(kv(s + 1, c) - kv(s, c), t - kt(e), kt(s + 1) - kt(s));
    endfunction

    function longint position(longint t, int c, int n);
      if (t <= kt(0)) return extrap_on ? beyond_end(0, t, c, n) : kv(0, c);
      if (t >= kt(n - 1)) return extrap_on ? beyond_end(n - 1, t, c, n) : kv(n - 1, c);
      for (int i = 0; i < n - 1; i++) begin
        if (t == kt(i)) return kv(i, c);
        if (t < kt(i + 1))
          return kv(i, c) + scale(kv(i + 1, c) - kv(i, c), t - kt(i), kt(i + 1) - kt(i));
      end
      return 0;
    endfunction

    function longint slope(longint t, int c, int n);
      int s;
      s = seg_for_slope(t, n);
      if (s < 0) return 0;
      return scale(kv(s + 1, c) - kv(s, c), 65536, kt(s + 1) - kt(s));
    endfunction

    function void set_reg(logic idx, logic [4:0] data);
      if (idx == REG_EXTRAPOLATE) extrap_on = data[0];
      else count_reg = int'(data);
    endfunction

    function void note_request(req_t r);
      longint v;
      res_t   e;
      v = 0;
      sat_flag = 1'b0;
      if (r.operation == OP_WRITE) begin
        times[r.knot_index] = r.knot_time;
        values[r.knot_index][r.component] = r.knot_value;
      end else if (r.operation == OP_POS || r.operation == OP_SLOPE) begin
        if (r.operation == OP_POS)
          v = position(longint'(r.query_time), r.component, knots_used());
        else
          v = slope(longint'(r.query_time), r.component, knots_used());
        if (v > 64'sd2147483647) begin
          v = 64'sd2147483647;
          sat_flag = 1'b1;
        end else if (v < -64'sd2147483648) begin
          v = -64'sd2147483648;
          sat_flag = 1'b1;
        end
      end
      e.result_value = v[31:0];
      e.error = sat_flag;
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    task check_result(res_t r);
      res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", r.result_value, 32'h0);
        return;
      end
      e = pending.pop_front();
      if (r.result_value !== e.result_value)
        report("result_value", r.result_value, e.result_value);
      if (r.error !== e.error) report("error", {31'b0, r.error}, {31'b0, e.error});
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic       req_valid_i = 1'b0;
  logic       req_stall_o;
  req_t       req_i = '0;
  logic       res_valid_o;
  logic       res_stall_i = 1'b0;
  res_t       res_o;

  interp_scoreboard sb = new();
  bit  quiet = 1'b0;
  int  stall_left = 0;
  logic signed [31:0] tbl[MaxKnots];

  piecewise_linear_interpolator_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_valid_i, .req_stall_o, .req_i, .res_valid_o, .res_stall_i, .res_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // check taken results, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) sb.check_result(res_o);
    if (quiet) begin
      res_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall_i <= 1'b1;
    end else if ($urandom_range(9) < 2) begin
      stall_left <= $urandom_range(4);
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= 1'b0;
    end
  end

  task send(req_t r);
    int gap;
    gap = (!quiet && $urandom_range(9) < 3) ? $urandom_range(5, 1) : 0;
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    sb.note_request(r);
  endtask

  task drain();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_reg(logic idx, logic [4:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task write_knot(int k, int c, logic [31:0] t, logic [31:0] v);
    req_t r;
    r = '0;
    r.operation = OP_WRITE;
    r.knot_index = k[3:0];
    r.component = c[1:0];
    r.knot_time = t;
    r.knot_value = v;
    r.query_time = $urandom;
    send(r);
  endtask

  task ask(op_e op, int c, logic [31:0] t);
    req_t r;
    r.operation = op;
    r.knot_index = 4'($urandom);
    r.component = c[1:0];
    r.knot_time = $urandom;
    r.knot_value = $urandom;
    r.query_time = t;
    send(r);
  endtask

  function logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  // fill all knots with increasing times; rarely repeat or reverse one
  task load_table(int spread);
    longint t;
    t = longint'($signed(32'($urandom))) / 4;
    if ($urandom_range(3) == 0) t = -64'sd2147483648 + $urandom_range(100);
    for (int k = 0; k < MaxKnots; k++) begin
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      tbl[k] = t[31:0];
      for (int c = 0; c < Components; c++) write_knot(k, c, tbl[k], pick_value());
      case ($urandom_range(19))
        0: t = t;
        1: t = t - $urandom_range(1000);
        default: t = t + $urandom_range(spread, 1);
      endcase
    end
  endtask

  function logic [31:0] pick_time();
    int k;
    k = $urandom_range(MaxKnots - 1);
    case ($urandom_range(6))
      0: return tbl[k];
      1: return tbl[k] + $urandom_range(3) - 1;
      2: return tbl[k] + $urandom_range(65536);
      3: return tbl[0] - $urandom_range(1 << 20);
      4: return tbl[MaxKnots - 1] + $urandom_range(1 << 20);
      5: return $urandom;
      default: return tbl[k] + ((tbl[(k + 1) % MaxKnots] - tbl[k]) >>> 1);
    endcase
  endfunction

  initial begin
    int phase_items;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: simple ramp, then the edges of every field
    write_reg(REG_KNOT_COUNT, 5'd16);
    for (int k = 0; k < MaxKnots; k++) begin
      tbl[k] = k * 32'h0001_0000;
      for (int c = 0; c < Components; c++) write_knot(k, c, tbl[k], (k * (c + 1)) << 16);
    end
    ask(OP_POS, 1, 32'h0002_8000);
    ask(OP_POS, 2, 32'h0003_0000);
    ask(OP_POS, 0, 32'h8000_0000);
    ask(OP_POS, 3, 32'h7fff_ffff);
    ask(OP_SLOPE, 3, 32'h8000_0000);
    ask(OP_SLOPE, 1, 32'h7fff_ffff);
    ask(OP_NONE, 0, 32'h0001_0000);
    write_reg(REG_EXTRAPOLATE, 5'd1);
    ask(OP_POS, 3, 32'h8000_0000);
    ask(OP_POS, 3, 32'h7fff_ffff);
    ask(OP_POS, 0, 32'hffff_0000);
    // zero-length first segment and extreme values saturate
    write_knot(1, 0, 32'h0, 32'h7fff_ffff);
    write_knot(0, 0, 32'h0, 32'h8000_0000);
    ask(OP_SLOPE, 0, 32'h0);
    ask(OP_POS, 0, 32'h8000_0000);
    // times out of order: no segment
    write_knot(3, 1, 32'h7fff_ffff, 32'h1234_5678);
    write_knot(5, 1, 32'h8000_0000, 32'h1);
    ask(OP_POS, 1, 32'h0004_8000);
    ask(OP_SLOPE, 1, 32'h0006_0000);
    write_reg(REG_KNOT_COUNT, 5'd0);
    ask(OP_POS, 2, 32'h0000_8000);
    write_reg(REG_KNOT_COUNT, 5'd31);
    ask(OP_POS, 2, 32'h000f_8000);

    // Random phases: fresh table, fresh settings, mostly queries
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(REG_EXTRAPOLATE, 5'($urandom));
      case (ph % 4)
        0: write_reg(REG_KNOT_COUNT, 5'd2);
        1: write_reg(REG_KNOT_COUNT, 5'd16);
        default: write_reg(REG_KNOT_COUNT, 5'($urandom));
      endcase
      load_table((ph % 3 == 0) ? (1 << 27) : $urandom_range(1 << 18, 16));
      if (ph == 12) quiet = 1'b1;
      phase_items = 30;
      for (int i = 0; i < phase_items; i++) begin
        if (i == 15 && ph == 5) drain();
        case ($urandom_range(19))
          0: write_knot($urandom_range(15), $urandom_range(3), pick_time(), pick_value());
          1: ask(OP_NONE, $urandom_range(3), $urandom);
          2, 3, 4, 5, 6, 7: ask(OP_SLOPE, $urandom_range(3), pick_time());
          default: ask(OP_POS, $urandom_range(3), pick_time());
        endcase
      end
    end

    req_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
